// ===== design/ils_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ils_pkg: shared types for the indexed list store
// Item and result structs, action and status codes, and the command that
// the sequencer broadcasts to the row of storage cells.
// ----------------------------------------------------------------------------
package ils_pkg;

  localparam int DATA_W       = 32;
  localparam int INDEX_W      = 8;
  localparam int COUNT_W      = 9;
  localparam int DEF_CAPACITY = 256;
  // Position width covers the largest supported capacity (4096 entries).
  localparam int POS_W        = 12;
  // Cells per group in the first stage of the read OR tree.
  localparam int GRP_SIZE     = 16;

  typedef enum logic [2:0] {
    ACT_APPEND = 3'd0,
    ACT_READ   = 3'd1,
    ACT_WRITE  = 3'd2,
    ACT_REMOVE = 3'd3,
    ACT_INSERT = 3'd4,
    ACT_CLEAR  = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_WRITE,
    CELL_SHIFT_DN,
    CELL_SHIFT_UP
  } cell_op_t;

  typedef struct packed {
    logic [2:0]                action;
    logic [INDEX_W-1:0]        index;
    logic signed [DATA_W-1:0]  value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  read_value;
    logic [1:0]                status;
    logic [COUNT_W-1:0]        count;
    logic                      is_empty;
  } out_item_t;

  typedef struct packed {
    cell_op_t                  op;
    logic                      rd_en;
    logic [POS_W-1:0]          pos;
    logic [DATA_W-1:0]         value;
  } cell_cmd_t;

endpackage
`default_nettype wire

// ===== design/ils_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ils_cell: one storage cell of the list
// Holds one entry; writes, takes its left or right neighbor's word on a
// shift, and drives its word onto the read tree when addressed.
// ----------------------------------------------------------------------------
module ils_cell
  import ils_pkg::*;
#(
  parameter int IDX = 0
) (
  input  wire logic              clk,
  input  wire cell_cmd_t         cmd,
  input  wire logic [DATA_W-1:0] left_q,
  input  wire logic [DATA_W-1:0] right_q,
  output logic [DATA_W-1:0]      data_q,
  output logic [DATA_W-1:0]      rd_q
);

  localparam logic [POS_W-1:0] MY_POS = POS_W'(IDX);

  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] data_nxt;
  logic              at_pos;
  logic              above_pos;

  assign at_pos    = (cmd.pos == MY_POS);
  assign above_pos = (MY_POS > cmd.pos);

  always_comb begin
    data_nxt = data_r;
    unique case (cmd.op)
      CELL_HOLD: begin
        data_nxt = data_r;
      end
      CELL_WRITE: begin
        if (at_pos) data_nxt = cmd.value;
      end
      // close the gap: every cell from the position up takes its right word
      CELL_SHIFT_DN: begin
        if (at_pos || above_pos) data_nxt = right_q;
      end
      // open a slot: cells above the position take their left word, the cell at it takes the value
      CELL_SHIFT_UP: begin
        if (above_pos)   data_nxt = left_q;
        else if (at_pos) data_nxt = cmd.value;
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q = data_r;
  assign rd_q   = (cmd.rd_en && at_pos) ? data_r : '0;

endmodule
`default_nettype wire

// ===== design/indexed_list_store_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_list_store_top: ordered list of signed words in a row of cells
// Sequencer, entry count and read tree around a chain of storage cells.
// ----------------------------------------------------------------------------
// An item is first accepted into the item register; then every cell of the row
// updates at once (shifting for remove and insert) while the first stage of the
// read OR tree registers groups of sixteen cells; then the second tree stage
// fills the result register. A new item is accepted while a finished result
// still waits on out_stall, but the row works on one item at a time: the input
// stalls until the result register is written. Only the first 256 cells can be
// read, since the index field is eight bits wide. Store contents are not cleared
// at reset; entries at or above the count are never returned.
module indexed_list_store_top
  import ils_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int RC = (CAPACITY < 256) ? CAPACITY : 256;
  localparam int NG = (RC + GRP_SIZE - 1) / GRP_SIZE;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_GATHER
  } state_t;

  state_t            state_r;
  in_item_t          item_r;
  logic [CW-1:0]     count_r;
  logic [CW-1:0]     count_nxt;
  logic [1:0]        status_r;
  status_t           status_nxt;
  logic              out_valid_r;
  out_item_t         out_r;
  cell_cmd_t         cmd;
  logic              idx_ok;
  logic              full;

  logic [DATA_W-1:0] cell_q [CAPACITY];
  logic [DATA_W-1:0] rd_q   [CAPACITY];
  logic [DATA_W-1:0] grp_r  [NG];
  logic [DATA_W-1:0] grp_nxt[NG];
  logic [DATA_W-1:0] rd_word;

  assign idx_ok = ((POS_W + 1)'(item_r.index) < (POS_W + 1)'(count_r));
  assign full   = (count_r == CW'(CAPACITY));

  // Decode the held item into a row command; only live in the update cycle.
  always_comb begin
    cmd        = '{op: CELL_HOLD, rd_en: 1'b0, pos: POS_W'(item_r.index),
                   value: item_r.value};
    count_nxt  = count_r;
    status_nxt = ST_OK;
    if (state_r == S_EXEC) begin
      unique case (item_r.action)
        ACT_APPEND: begin
          if (full) begin
            status_nxt = ST_FULL;
          end else begin
            cmd.op    = CELL_WRITE;
            cmd.pos   = POS_W'(count_r);
            count_nxt = count_r + CW'(1);
          end
        end
        ACT_READ: begin
          if (!idx_ok) status_nxt = ST_RANGE;
          else         cmd.rd_en  = 1'b1;
        end
        ACT_WRITE: begin
          if (!idx_ok) status_nxt = ST_RANGE;
          else         cmd.op     = CELL_WRITE;
        end
        ACT_REMOVE: begin
          if (!idx_ok) begin
            status_nxt = ST_RANGE;
          end else begin
            cmd.op    = CELL_SHIFT_DN;
            count_nxt = count_r - CW'(1);
          end
        end
        ACT_INSERT: begin
          if (!idx_ok) begin
            status_nxt = ST_RANGE;
          end else if (full) begin
            status_nxt = ST_FULL;
          end else begin
            cmd.op    = CELL_SHIFT_UP;
            count_nxt = count_r + CW'(1);
          end
        end
        ACT_CLEAR: begin
          count_nxt = '0;
        end
        default: begin
          count_nxt = count_r;
        end
      endcase
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left_w;
    logic [DATA_W-1:0] right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_q[i+1];
    end
    ils_cell #(.IDX(i)) u_cell (
      .clk     (clk),
      .cmd     (cmd),
      .left_q  (left_w),
      .right_q (right_w),
      .data_q  (cell_q[i]),
      .rd_q    (rd_q[i])
    );
  end

  // First tree stage: OR each group of cells, registered.
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_nxt[g] = '0;
      for (int k = 0; k < GRP_SIZE; k++) begin
        if (g * GRP_SIZE + k < RC) grp_nxt[g] = grp_nxt[g] | rd_q[g * GRP_SIZE + k];
      end
    end
  end

  // Capture only in the update cycle; hold while the result waits.
  always_ff @(posedge clk) begin
    if (state_r == S_EXEC) grp_r <= grp_nxt;
  end

  // Second tree stage: OR across the groups.
  always_comb begin
    rd_word = '0;
    for (int g = 0; g < NG; g++) begin
      rd_word = rd_word | grp_r[g];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && state_r != S_GATHER) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            item_r  <= in_data;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          count_r  <= count_nxt;
          status_r <= status_nxt;
          state_r  <= S_GATHER;
        end
        S_GATHER: begin
          // hold until the result register is free
          if (!out_valid_r || !out_stall) begin
            out_r.read_value <= rd_word;
            out_r.status     <= status_r;
            out_r.count      <= COUNT_W'(count_r);
            out_r.is_empty   <= (count_r == '0);
            out_valid_r      <= 1'b1;
            state_r          <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

// ===== design/ils_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ils_checker: port-level checks for the indexed list store
// Watches the top level's channels and flags results that break its rules.
// ----------------------------------------------------------------------------
module ils_checker
  import ils_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_data
);

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  // the row works on one item at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after an accepted item");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == ST_OK) || (out_data.status == ST_RANGE)
                  || (out_data.status == ST_FULL))
    else $error("unknown status code");

  // a failed action never returns store data
  a_fail_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ST_OK) |-> (out_data.read_value == '0))
    else $error("read data on a failed action");

endmodule

bind indexed_list_store_top ils_checker u_ils_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire
